@@ rtl/core/number_text_parser_unit_assert.svh @@
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef NUMBER_TEXT_PARSER_UNIT_ASSERT_SVH
`define NUMBER_TEXT_PARSER_UNIT_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define NTP_ASSERT_SAME(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("ntp check failed");

// condition holds in the cycle after the trigger
`define NTP_ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("ntp check failed");

`endif

@@ rtl/core/ntp_pkg.sv @@
package ntp_pkg;

	localparam int unsigned ValW = 64;

	// character codes
	localparam logic [7:0] ChNul   = 8'h00;
	localparam logic [7:0] ChPlus  = 8'h2B;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChSeven = 8'h37;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpF   = 8'h46;
	localparam logic [7:0] ChLoA   = 8'h61;
	localparam logic [7:0] ChLoF   = 8'h66;
	localparam logic [7:0] ChUpB   = 8'h42;
	localparam logic [7:0] ChLoB   = 8'h62;
	localparam logic [7:0] ChUpG   = 8'h47;
	localparam logic [7:0] ChLoG   = 8'h67;
	localparam logic [7:0] ChUpK   = 8'h4B;
	localparam logic [7:0] ChLoK   = 8'h6B;
	localparam logic [7:0] ChUpM   = 8'h4D;
	localparam logic [7:0] ChLoM   = 8'h6D;
	localparam logic [7:0] ChUpX   = 8'h58;
	localparam logic [7:0] ChLoX   = 8'h78;

	typedef enum logic [7:0] {
		PH_START  = 8'b0000_0001,
		PH_SIGNED = 8'b0000_0010,
		PH_ZERO   = 8'b0000_0100,
		PH_OCT    = 8'b0000_1000,
		PH_HEX    = 8'b0001_0000,
		PH_DEC    = 8'b0010_0000,
		PH_SUFFIX = 8'b0100_0000,
		PH_DONE   = 8'b1000_0000
	} phase_t;

	typedef enum logic [1:0] {
		SFX_NONE = 2'd0,
		SFX_K    = 2'd1,
		SFX_M    = 2'd2,
		SFX_G    = 2'd3
	} sfx_t;

	// finished number handed from the parser to the scaler
	typedef struct packed {
		logic            valid;
		logic [ValW-1:0] accum;
		logic            negative;
		logic            err;
		sfx_t            bin_kind;
		sfx_t            dec_kind;
	} req_t;

	// value in flight through the scaler
	typedef struct packed {
		logic [ValW-1:0] value;
		logic [1:0]      cnt;
		logic            err;
	} stg_t;

	function automatic logic [ValW-1:0] times1000(input logic [ValW-1:0] x);
		times1000 = (x << 10) - (x << 4) - (x << 3);
	endfunction

endpackage

@@ rtl/core/ntp_parser.sv @@
module ntp_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          acc,
	input  logic [7:0]    ch,
	output ntp_pkg::req_t req
);
	import ntp_pkg::*;

	phase_t          phase_q, phase_d;
	logic            neg_q, neg_d;
	logic [ValW-1:0] accum_q, accum_d;
	logic            err_q, err_d;
	sfx_t            kind_q, kind_d;
	logic            bin_q, bin_d;
	logic            dec_q, dec_d;

	logic            is_dec, is_oct, is_hex_alpha;
	logic [3:0]      hex_val;
	logic [ValW-1:0] dig;
	logic            body_ok;
	sfx_t            body_kind;

	assign is_dec       = (ch >= ChZero) && (ch <= ChNine);
	assign is_oct       = (ch >= ChZero) && (ch <= ChSeven);
	assign is_hex_alpha = ((ch >= ChLoA) && (ch <= ChLoF)) || ((ch >= ChUpA) && (ch <= ChUpF));
	// low nibble of '0'..'9' is the digit, of 'a'..'f' / 'A'..'F' it is 1..6
	assign hex_val      = is_dec ? ch[3:0] : ch[3:0] + 4'd9;
	assign dig          = {{(ValW-4){1'b0}}, hex_val};

	// a suffix character (k, m or g) that ends a digit run
	always_comb begin
		body_ok   = 1'b1;
		body_kind = SFX_NONE;
		if (ch == ChLoK || ch == ChUpK) begin
			body_kind = SFX_K;
		end else if (ch == ChLoM || ch == ChUpM) begin
			body_kind = SFX_M;
		end else if (ch == ChLoG || ch == ChUpG) begin
			body_kind = SFX_G;
		end else begin
			body_ok = 1'b0;
		end
	end

	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		accum_d = accum_q;
		err_d   = err_q;
		kind_d  = kind_q;
		bin_d   = bin_q;
		dec_d   = dec_q;
		if (ch == ChNul) begin
			phase_d = PH_START;
			neg_d   = 1'b0;
			accum_d = '0;
			err_d   = 1'b0;
			kind_d  = SFX_NONE;
			bin_d   = 1'b0;
			dec_d   = 1'b0;
		end else begin
			case (phase_q)
				PH_START, PH_SIGNED: begin
					if (phase_q == PH_START && (ch == ChPlus || ch == ChMinus)) begin
						neg_d   = (ch == ChMinus);
						phase_d = PH_SIGNED;
					end else if (ch == ChZero) begin
						phase_d = PH_ZERO;
					end else if (is_dec) begin
						accum_d = dig;
						phase_d = PH_DEC;
					end else begin
						err_d   = 1'b1;
						phase_d = PH_DONE;
					end
				end
				PH_ZERO, PH_OCT: begin
					if (phase_q == PH_ZERO && (ch == ChLoX || ch == ChUpX)) begin
						phase_d = PH_HEX;
					end else if (is_oct) begin
						accum_d = (accum_q << 3) + dig;
						phase_d = PH_OCT;
					end else if (body_ok) begin
						kind_d  = body_kind;
						phase_d = PH_SUFFIX;
					end else begin
						err_d   = 1'b1;
						phase_d = PH_DONE;
					end
				end
				PH_HEX: begin
					if (is_dec || is_hex_alpha) begin
						accum_d = (accum_q << 4) + dig;
					end else if (body_ok) begin
						kind_d  = body_kind;
						phase_d = PH_SUFFIX;
					end else begin
						err_d   = 1'b1;
						phase_d = PH_DONE;
					end
				end
				PH_DEC: begin
					if (is_dec) begin
						accum_d = (accum_q << 3) + (accum_q << 1) + dig;
					end else if (body_ok) begin
						kind_d  = body_kind;
						phase_d = PH_SUFFIX;
					end else begin
						err_d   = 1'b1;
						phase_d = PH_DONE;
					end
				end
				PH_SUFFIX: begin
					if (ch == ChLoB) begin
						dec_d = 1'b1;
					end else if (ch == ChUpB) begin
						bin_d = 1'b1;
					end else begin
						err_d = 1'b1;
					end
					phase_d = PH_DONE;
				end
				default: begin
					phase_d = PH_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			accum_q <= '0;
			err_q   <= 1'b0;
			kind_q  <= SFX_NONE;
			bin_q   <= 1'b0;
			dec_q   <= 1'b0;
		end else if (acc) begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			accum_q <= accum_d;
			err_q   <= err_d;
			kind_q  <= kind_d;
			bin_q   <= bin_d;
			dec_q   <= dec_d;
		end
	end

	// end of text: the request is built from the state before the nul
	always_comb begin
		req.valid    = acc && (ch == ChNul);
		req.accum    = accum_q;
		req.negative = neg_q;
		req.err      = err_q || (phase_q == PH_START) || (phase_q == PH_SIGNED);
		req.bin_kind = ((phase_q == PH_SUFFIX) || bin_q) ? kind_q : SFX_NONE;
		req.dec_kind = dec_q ? kind_q : SFX_NONE;
	end

endmodule

@@ rtl/core/ntp_scaler.sv @@
module ntp_scaler (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ntp_pkg::req_t            req,
	output logic                     req_ready,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ntp_pkg::ValW-1:0] out_value,
	output logic                     out_err
);
	import ntp_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	stg_t d_s1, d_s2, d_s3, d_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	stg_t fin;
	logic [ValW-1:0] shifted;

	assign rdy4 = !v_s4 || out_ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign req_ready = rdy1;

	// binary suffix, sign and error folded in before the decimal factors
	always_comb begin
		case (req.bin_kind)
			SFX_K:   shifted = req.accum << 10;
			SFX_M:   shifted = req.accum << 20;
			SFX_G:   shifted = req.accum << 30;
			default: shifted = req.accum;
		endcase
		fin.err   = req.err;
		fin.cnt   = req.err ? 2'd0 : req.dec_kind;
		if (req.err) begin
			fin.value = '0;
		end else if (req.negative) begin
			fin.value = '0 - shifted;
		end else begin
			fin.value = shifted;
		end
	end

	function automatic stg_t step1000(input stg_t s);
		stg_t r;
		r = s;
		if (s.cnt != 2'd0) begin
			r.value = times1000(s.value);
			r.cnt   = s.cnt - 2'd1;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= req.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && req.valid) d_s1 <= fin;
		if (rdy2 && v_s1) d_s2 <= step1000(d_s1);
		if (rdy3 && v_s2) d_s3 <= step1000(d_s2);
		if (rdy4 && v_s3) d_s4 <= step1000(d_s3);
	end

	assign out_valid = v_s4;
	assign out_value = d_s4.value;
	assign out_err   = d_s4.err;

endmodule

@@ rtl/core/number_text_parser_unit.sv @@
// number text parser
// takes one character per request on the char channel (ch, char_valid,
// char_ready) and returns one result per nul character on the result
// channel (value, malformed, result_valid, result_ready)
// text: optional sign, decimal / octal (leading 0) / hex (0x) body, then an
// optional k, m or g suffix; a following b scales by powers of 1000, a
// following B or the end of text by powers of 1024
// throughput: one character per cycle while char_ready is high, every character including the nul
// after its nul is taken, a result is registered through the four-stage
// scaler (sign and binary shift, then up to three x1000 stages)
// malformed text gives value 0 with malformed set
// reset clears the parser and empties the scaler, ready for a new number
// a stalled result holds in the last stage; the stages behind it keep
// filling, and char_ready drops only once all four are full
module number_text_parser_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         char_valid,
	output logic                         char_ready,
	input  logic [7:0]                   ch,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic signed [ntp_pkg::ValW-1:0] value,
	output logic                         malformed
);
	import ntp_pkg::*;

	logic            acc;
	req_t            req;
	logic [ValW-1:0] out_value;

	assign acc = char_valid && char_ready;

	ntp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.ch     (ch),
		.req    (req)
	);

	ntp_scaler u_scaler (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_ready (char_ready),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_value (out_value),
		.out_err   (malformed)
	);

	assign value = $signed(out_value);

`include "number_text_parser_unit_assert.svh"

	`NTP_ASSERT_SAME(a_err_zero, result_valid && malformed, value == '0)
	`NTP_ASSERT_SAME(a_full_only_when_blocked, !char_ready, result_valid && !result_ready)
	`NTP_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid && $stable(value))

endmodule
